// ===== src/erot_pkg.sv =====
// shared types, constants and tables for the euler xyz vector rotation block
`default_nettype none

package erot_pkg;

    // field widths
    localparam int COORD_W = 32;
    localparam int ANG_W = 32;
    localparam int TRIG_FRAC_BITS_DEF = 16;

    // reduced angle magnitude, |d| <= 45 degrees in q16.16
    localparam int MAG_W = 22;

    // q30 trig arithmetic
    localparam int Q30_W = 30;
    localparam int T_W = 31;
    localparam logic [T_W-1:0] Q30_ONE = 31'h4000_0000;
    localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;

    // series terms and reciprocals floor(2^32 / div)
    localparam int N_SIN = 5;
    localparam int N_COS = 6;
    localparam logic [7:0] SIN_DIV [N_SIN] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_DIV [N_COS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [31:0] SIN_RECIP [N_SIN] = '{
        32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882
    };
    localparam logic [31:0] COS_RECIP [N_COS] = '{
        32'd32537631, 32'd47721858, 32'd76695844, 32'd143165576, 32'd357913941,
        32'd2147483648
    };

    // pipeline and queue depths
    localparam int TRIG_LAT = 22;
    localparam int QDEPTH = 4;

    // quadrant of the reduced angle
    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } t_quad;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_vec3;

    typedef struct packed {
        t_quad quad;
        logic neg;
        logic [MAG_W-1:0] mag;
    } t_red_ang;

    typedef struct packed {
        t_red_ang ang_x;
        t_red_ang ang_y;
        t_red_ang ang_z;
        t_vec3 vec;
    } t_red_beat;

    typedef struct packed {
        logic signed [ANG_W-1:0] angle_x_deg;
        logic signed [ANG_W-1:0] angle_y_deg;
        logic signed [ANG_W-1:0] angle_z_deg;
        logic signed [COORD_W-1:0] vec_x;
        logic signed [COORD_W-1:0] vec_y;
        logic signed [COORD_W-1:0] vec_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_W-1:0] rot_x;
        logic signed [COORD_W-1:0] rot_y;
        logic signed [COORD_W-1:0] rot_z;
        logic saturated;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== src/erot_front.sv =====
// front end: input beat acceptance and angle reduction to quadrant and offset
`default_nettype none

module erot_front import erot_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_push,
    output t_red_beat o_push_data,
    input  logic      i_full
);

    localparam logic [10:0] MOD_RECIP = 11'd1456;
    localparam logic [13:0] MOD_BASE = 14'd45;
    localparam logic [5:0] MOD_TOP = 6'd44;
    localparam logic [24:0] DEG45 = 25'd2949120;
    localparam logic [24:0] DEG135 = 25'd8847360;
    localparam logic [24:0] DEG225 = 25'd14745600;
    localparam logic [24:0] DEG315 = 25'd20643840;
    localparam logic [25:0] QTR1 = 26'd5898240;
    localparam logic [25:0] QTR2 = 26'd11796480;
    localparam logic [25:0] QTR3 = 26'd17694720;
    localparam logic [25:0] QTR4 = 26'd23592960;

    logic             fe;
    logic [2:0]       r_fv;
    logic [ANG_W-1:0] angs [3];

    logic [12:0] n_u [3];
    logic [7:0]  n_qe [3];
    logic [23:0] prod [3];
    logic [12:0] r_u [3];
    logic [7:0]  r_qe [3];
    logic [18:0] r_low [3];
    t_vec3       r_vec1;

    logic [13:0] qd [3];
    logic [13:0] rem0 [3];
    logic [13:0] rem1 [3];
    logic [5:0]  mres [3];
    logic [24:0] n_r [3];
    logic [24:0] r_r [3];
    t_vec3       r_vec2;

    logic [2:0]         qn [3];
    logic [25:0]        qoff [3];
    logic signed [25:0] dd [3];
    t_red_ang           n_ang [3];
    t_red_beat          r_out;

    // the whole front shifts unless its last beat is blocked by a full queue
    assign fe = !(r_fv[2] && i_full);
    assign o_in_ready = fe;
    assign o_push = r_fv[2] && !i_full;
    assign o_push_data = r_out;

    assign angs[0] = i_in_data.angle_x_deg;
    assign angs[1] = i_in_data.angle_y_deg;
    assign angs[2] = i_in_data.angle_z_deg;

    // stage 1: split off 2^19 units and estimate the quotient by 45
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_u[i] = {~angs[i][31], angs[i][30:19]};
            prod[i] = 24'(n_u[i]) * 24'(MOD_RECIP);
            n_qe[i] = prod[i][23:16];
        end
    end

    // stage 2: finish the mod 45 and form the angle in [0,360)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qd[i] = 14'(r_qe[i]) * MOD_BASE;
            rem0[i] = 14'(r_u[i]) - qd[i];
            rem1[i] = (rem0[i] >= MOD_BASE) ? rem0[i] - MOD_BASE : rem0[i];
            mres[i] = (rem1[i][5:0] == 6'd0) ? MOD_TOP : rem1[i][5:0] - 6'd1;
            n_r[i] = {mres[i], r_low[i]};
        end
    end

    // stage 3: pick the nearest quadrant and the signed offset from it
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qn[i] = 3'(r_r[i] >= DEG45) + 3'(r_r[i] >= DEG135)
                  + 3'(r_r[i] >= DEG225) + 3'(r_r[i] >= DEG315);
            case (qn[i])
                3'd0: qoff[i] = '0;
                3'd1: qoff[i] = QTR1;
                3'd2: qoff[i] = QTR2;
                3'd3: qoff[i] = QTR3;
                default: qoff[i] = QTR4;
            endcase
            dd[i] = signed'({1'b0, r_r[i]} - qoff[i]);
            n_ang[i].quad = t_quad'(qn[i][1:0]);
            n_ang[i].neg = dd[i][25];
            n_ang[i].mag = dd[i][25] ? MAG_W'(-dd[i]) : MAG_W'(dd[i]);
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (fe) begin
            r_fv <= {r_fv[1:0], i_in_valid};
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_u <= n_u;
            r_qe <= n_qe;
            for (int i = 0; i < 3; i++) begin
                r_low[i] <= angs[i][18:0];
            end
            r_vec1.x <= i_in_data.vec_x;
            r_vec1.y <= i_in_data.vec_y;
            r_vec1.z <= i_in_data.vec_z;
            r_r <= n_r;
            r_vec2 <= r_vec1;
            r_out.ang_x <= n_ang[0];
            r_out.ang_y <= n_ang[1];
            r_out.ang_z <= n_ang[2];
            r_out.vec <= r_vec2;
        end
    end

endmodule

`default_nettype wire

// ===== src/erot_fifo.sv =====
// small queue of reduced beats between the front end and the back end
`default_nettype none

module erot_fifo import erot_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_red_beat i_push_data,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_not_empty,
    output t_red_beat o_head
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_red_beat        r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full = (r_cnt == CNT_W'(QDEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_head = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QDEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // queue never overruns or underruns
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_not_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== src/erot_trig.sv =====
// pipelined sine and cosine of a reduced angle by truncated q30 series
`default_nettype none

module erot_trig import erot_pkg::*; #(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  t_red_ang                        i_ang,
    output logic signed [TRIG_FRAC_BITS+1:0] o_sin,
    output logic signed [TRIG_FRAC_BITS+1:0] o_cos
);

    localparam int TV_W = TRIG_FRAC_BITS + 2;
    localparam int H_N = 3 * N_COS;
    localparam logic [48:0] X_RND = 49'd131072;

    function automatic logic [TRIG_FRAC_BITS:0] rnd(input logic [T_W-1:0] v);
        logic [T_W:0] t;
        t = {1'b0, v} + ((T_W + 1)'(1) << (29 - TRIG_FRAC_BITS));
        return (TRIG_FRAC_BITS + 1)'(t >> (30 - TRIG_FRAC_BITS));
    endfunction

    logic [48:0]      n_xp;
    logic [Q30_W-1:0] r_x1;
    t_quad            r_quad1;
    logic             r_neg1;

    logic [59:0]      n_sq;
    logic [Q30_W-1:0] r_x2;
    logic [Q30_W-1:0] r_x2x;
    t_quad            r_quad2;
    logic             r_neg2;

    logic [Q30_W-1:0] sb_x2 [H_N];
    logic [Q30_W-1:0] sb_x [H_N];
    t_quad            sb_quad [H_N];
    logic             sb_neg [H_N];

    logic [Q30_W-1:0] r_cp [N_COS];
    logic [Q30_W-1:0] r_cp2 [N_COS];
    logic [Q30_W-1:0] r_cq [N_COS];
    logic [T_W-1:0]   r_ct [N_COS];
    logic [Q30_W-1:0] r_sp [N_SIN];
    logic [Q30_W-1:0] r_sp2 [N_SIN];
    logic [Q30_W-1:0] r_sq [N_SIN];
    logic [T_W-1:0]   r_st [N_SIN];

    logic [60:0]      n_sp;
    logic [Q30_W-1:0] r_sr;
    logic [T_W-1:0]   r_cf;
    t_quad            r_quadf;
    logic             r_negf;

    logic signed [TV_W-1:0] s_sg;
    logic signed [TV_W-1:0] c_sg;
    logic signed [TV_W-1:0] n_sin;
    logic signed [TV_W-1:0] n_cos;
    logic signed [TV_W-1:0] r_sin;
    logic signed [TV_W-1:0] r_cos;

    // degrees to radians in q30
    assign n_xp = 49'(i_ang.mag) * 49'(DEG_TO_RAD_Q32) + X_RND;
    // x squared
    assign n_sq = 60'(r_x1) * 60'(r_x1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1 <= n_xp[47:18];
            r_quad1 <= i_ang.quad;
            r_neg1 <= i_ang.neg;
            r_x2 <= n_sq[59:30];
            r_x2x <= r_x1;
            r_quad2 <= r_quad1;
            r_neg2 <= r_neg1;
        end
    end

    // side band travelling with the series stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            sb_x2[0] <= r_x2;
            sb_x[0] <= r_x2x;
            sb_quad[0] <= r_quad2;
            sb_neg[0] <= r_neg2;
            for (int i = 1; i < H_N; i++) begin
                sb_x2[i] <= sb_x2[i-1];
                sb_x[i] <= sb_x[i-1];
                sb_quad[i] <= sb_quad[i-1];
                sb_neg[i] <= sb_neg[i-1];
            end
        end
    end

    // cosine series, one term per three stages: product, reciprocal, fix-up
    for (genvar k = 0; k < N_COS; k++) begin : g_cos
        logic [Q30_W-1:0] c_x2_in;
        logic [T_W-1:0]   c_t_in;
        logic [60:0]      c_pp;
        logic [61:0]      c_pm;
        logic [37:0]      c_qd;
        logic [37:0]      c_rem;
        logic [Q30_W-1:0] c_qf;

        if (k == 0) begin : g_first
            assign c_x2_in = r_x2;
            assign c_t_in = Q30_ONE;
        end else begin : g_next
            assign c_x2_in = sb_x2[3*k-1];
            assign c_t_in = r_ct[k-1];
        end

        assign c_pp = 61'(c_x2_in) * 61'(c_t_in);
        assign c_pm = 62'(r_cp[k]) * 62'(COS_RECIP[k]);
        assign c_qd = 38'(r_cq[k]) * 38'(COS_DIV[k]);
        assign c_rem = 38'(r_cp2[k]) - c_qd;
        assign c_qf = r_cq[k] + Q30_W'(c_rem >= 38'(COS_DIV[k]));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cp[k] <= c_pp[59:30];
                r_cq[k] <= c_pm[61:32];
                r_cp2[k] <= r_cp[k];
                r_ct[k] <= Q30_ONE - T_W'(c_qf);
            end
        end
    end

    // sine series, running one term behind the cosine so both end together
    for (genvar k = 0; k < N_SIN; k++) begin : g_sin
        logic [T_W-1:0]   s_t_in;
        logic [60:0]      s_pp;
        logic [61:0]      s_pm;
        logic [37:0]      s_qd;
        logic [37:0]      s_rem;
        logic [Q30_W-1:0] s_qf;

        if (k == 0) begin : g_first
            assign s_t_in = Q30_ONE;
        end else begin : g_next
            assign s_t_in = r_st[k-1];
        end

        assign s_pp = 61'(sb_x2[3*k+2]) * 61'(s_t_in);
        assign s_pm = 62'(r_sp[k]) * 62'(SIN_RECIP[k]);
        assign s_qd = 38'(r_sq[k]) * 38'(SIN_DIV[k]);
        assign s_rem = 38'(r_sp2[k]) - s_qd;
        assign s_qf = r_sq[k] + Q30_W'(s_rem >= 38'(SIN_DIV[k]));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sp[k] <= s_pp[59:30];
                r_sq[k] <= s_pm[61:32];
                r_sp2[k] <= r_sp[k];
                r_st[k] <= Q30_ONE - T_W'(s_qf);
            end
        end
    end

    // sine = x times series
    assign n_sp = 61'(sb_x[H_N-1]) * 61'(r_st[N_SIN-1]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr <= n_sp[59:30];
            r_cf <= r_ct[N_COS-1];
            r_quadf <= sb_quad[H_N-1];
            r_negf <= sb_neg[H_N-1];
        end
    end

    // round to output precision, apply offset sign and quadrant
    always_comb begin
        s_sg = signed'(TV_W'(rnd({1'b0, r_sr})));
        if (r_negf) begin
            s_sg = -s_sg;
        end
        c_sg = signed'(TV_W'(rnd(r_cf)));
        case (r_quadf)
            QUAD_0: begin
                n_sin = s_sg;
                n_cos = c_sg;
            end
            QUAD_1: begin
                n_sin = c_sg;
                n_cos = -s_sg;
            end
            QUAD_2: begin
                n_sin = -s_sg;
                n_cos = -c_sg;
            end
            QUAD_3: begin
                n_sin = -c_sg;
                n_cos = s_sg;
            end
            default: begin
                n_sin = s_sg;
                n_cos = c_sg;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

`default_nettype wire

// ===== src/erot_back.sv =====
// back end: trig for the three angles and the three rotation stages
`default_nettype none

module erot_back import erot_pkg::*; #(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_not_empty,
    output logic      o_pop,
    input  t_red_beat i_head,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    localparam int TV_W = TRIG_FRAC_BITS + 2;
    localparam int PW = COORD_W + TV_W;
    localparam int SW = PW + 1;
    localparam int WW = SW - TRIG_FRAC_BITS;
    localparam int N_ST = 1 + TRIG_LAT + 6;

    // exact sum of two products, rounded half up and clipped; msb is the clip flag
    function automatic logic [COORD_W:0] rclamp(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] t;
        logic signed [WW-1:0] w;
        logic [COORD_W-1:0] lo;
        t = s + (SW'(1) <<< (TRIG_FRAC_BITS - 1));
        w = WW'(t >>> TRIG_FRAC_BITS);
        lo = w[COORD_W-1:0];
        if (w == WW'(signed'(lo))) begin
            return {1'b0, lo};
        end else if (w[WW-1]) begin
            return {1'b1, 1'b1, {(COORD_W - 1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(COORD_W - 1){1'b1}}};
        end
    endfunction

    function automatic logic signed [PW-1:0] mul(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [TV_W-1:0] t);
        return PW'(a) * PW'(t);
    endfunction

    logic            be;
    logic [N_ST-1:0] r_bv;
    t_red_beat       r_b0;
    t_vec3           r_vd [TRIG_LAT];

    logic signed [TV_W-1:0] sx, cx, sy, cy, sz, cz;
    logic signed [TV_W-1:0] r_ty_s [2];
    logic signed [TV_W-1:0] r_ty_c [2];
    logic signed [TV_W-1:0] r_tz_s [4];
    logic signed [TV_W-1:0] r_tz_c [4];

    logic signed [PW-1:0]      r_p1 [4];
    logic signed [PW-1:0]      r_p2 [4];
    logic signed [PW-1:0]      r_p3 [4];
    logic signed [COORD_W-1:0] r_x_a, r_x_b, r_y_a, r_y_b, r_z_a;
    logic signed [COORD_W-1:0] r_y1, r_z1, r_x2, r_z2;
    logic                      r_sat1, r_sat2a, r_sat2, r_sat3a;
    logic [COORD_W:0]          n_r1y, n_r1z, n_r2x, n_r2z, n_r3x, n_r3y;
    t_out_beat                 r_out;

    // the back pipeline moves as one unless the output beat is held
    assign be = !r_bv[N_ST-1] || i_out_ready;
    assign o_pop = i_not_empty && be;
    assign o_out_valid = r_bv[N_ST-1];
    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (be) begin
            r_bv <= {r_bv[N_ST-2:0], o_pop};
        end
    end

    // queue head register and vector delay line matching the trig latency
    always_ff @(posedge i_clk) begin
        if (be) begin
            r_b0 <= i_head;
            r_vd[0] <= r_b0.vec;
            for (int i = 1; i < TRIG_LAT; i++) begin
                r_vd[i] <= r_vd[i-1];
            end
        end
    end

    erot_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_x (
        .i_clk (i_clk),
        .i_en  (be),
        .i_ang (r_b0.ang_x),
        .o_sin (sx),
        .o_cos (cx)
    );

    erot_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_y (
        .i_clk (i_clk),
        .i_en  (be),
        .i_ang (r_b0.ang_y),
        .o_sin (sy),
        .o_cos (cy)
    );

    erot_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_z (
        .i_clk (i_clk),
        .i_en  (be),
        .i_ang (r_b0.ang_z),
        .o_sin (sz),
        .o_cos (cz)
    );

    // round and clip the product pairs
    assign n_r1y = rclamp(SW'(r_p1[0]) + SW'(r_p1[1]));
    assign n_r1z = rclamp(SW'(r_p1[2]) + SW'(r_p1[3]));
    assign n_r2x = rclamp(SW'(r_p2[0]) + SW'(r_p2[1]));
    assign n_r2z = rclamp(SW'(r_p2[2]) + SW'(r_p2[3]));
    assign n_r3x = rclamp(SW'(r_p3[0]) + SW'(r_p3[1]));
    assign n_r3y = rclamp(SW'(r_p3[2]) + SW'(r_p3[3]));

    // rotation about x, then y, then z: products stage then sum stage each
    always_ff @(posedge i_clk) begin
        if (be) begin
            r_ty_s[0] <= sy;
            r_ty_c[0] <= cy;
            r_ty_s[1] <= r_ty_s[0];
            r_ty_c[1] <= r_ty_c[0];
            r_tz_s[0] <= sz;
            r_tz_c[0] <= cz;
            for (int i = 1; i < 4; i++) begin
                r_tz_s[i] <= r_tz_s[i-1];
                r_tz_c[i] <= r_tz_c[i-1];
            end

            // x axis
            r_p1[0] <= mul(r_vd[TRIG_LAT-1].y, cx);
            r_p1[1] <= mul(r_vd[TRIG_LAT-1].z, -sx);
            r_p1[2] <= mul(r_vd[TRIG_LAT-1].y, sx);
            r_p1[3] <= mul(r_vd[TRIG_LAT-1].z, cx);
            r_x_a <= r_vd[TRIG_LAT-1].x;
            r_y1 <= n_r1y[COORD_W-1:0];
            r_z1 <= n_r1z[COORD_W-1:0];
            r_sat1 <= n_r1y[COORD_W] | n_r1z[COORD_W];
            r_x_b <= r_x_a;

            // y axis
            r_p2[0] <= mul(r_x_b, r_ty_c[1]);
            r_p2[1] <= mul(r_z1, r_ty_s[1]);
            r_p2[2] <= mul(r_x_b, -r_ty_s[1]);
            r_p2[3] <= mul(r_z1, r_ty_c[1]);
            r_y_a <= r_y1;
            r_sat2a <= r_sat1;
            r_x2 <= n_r2x[COORD_W-1:0];
            r_z2 <= n_r2z[COORD_W-1:0];
            r_sat2 <= r_sat2a | n_r2x[COORD_W] | n_r2z[COORD_W];
            r_y_b <= r_y_a;

            // z axis
            r_p3[0] <= mul(r_x2, r_tz_c[3]);
            r_p3[1] <= mul(r_y_b, -r_tz_s[3]);
            r_p3[2] <= mul(r_x2, r_tz_s[3]);
            r_p3[3] <= mul(r_y_b, r_tz_c[3]);
            r_z_a <= r_z2;
            r_sat3a <= r_sat2;
            r_out.rot_x <= n_r3x[COORD_W-1:0];
            r_out.rot_y <= n_r3y[COORD_W-1:0];
            r_out.rot_z <= r_z_a;
            r_out.saturated <= r_sat3a | n_r3x[COORD_W] | n_r3y[COORD_W];
        end
    end

    // held pipeline keeps its valid pattern
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !be |=> r_bv == $past(r_bv))
        else $error("back pipeline moved while stalled");
    // sine of x and cosines of y and z never exceed one in magnitude
    a_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bv[TRIG_LAT] |->
            (sx <= TV_W'(1 << TRIG_FRAC_BITS)) && (sx >= -TV_W'(1 << TRIG_FRAC_BITS)) &&
            (cy <= TV_W'(1 << TRIG_FRAC_BITS)) && (cy >= -TV_W'(1 << TRIG_FRAC_BITS)) &&
            (cz <= TV_W'(1 << TRIG_FRAC_BITS)) && (cz >= -TV_W'(1 << TRIG_FRAC_BITS)))
        else $error("trig value out of range");

endmodule

`default_nettype wire

// ===== src/euler_xyz_vector_rotation.sv =====
// top level of the euler xyz vector rotation block
`default_nettype none

// Rotates a q16.16 vector about x, then y, then z by three q16.16 degree
// angles and returns the saturated result with a clip flag. The block is
// fully pipelined and takes one beat per clock when the output side does
// not stall. A three-stage front end reduces the angles to quadrant and
// offset and feeds a four-entry queue; the back end runs the sine and
// cosine series (22 stages) and the three rotation stages (two stages each).
// Backpressure on the output holds the back end; the queue then lets the
// front end keep taking beats until it fills.
module euler_xyz_vector_rotation import erot_pkg::*; #(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    logic      push;
    t_red_beat push_data;
    logic      full;
    logic      pop;
    logic      not_empty;
    t_red_beat head;

    // angle reduction
    erot_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    // decoupling queue
    erot_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_not_empty (not_empty),
        .o_head      (head)
    );

    // trig and rotation
    erot_back #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_not_empty (not_empty),
        .o_pop       (pop),
        .i_head      (head),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== dv/tb_euler_xyz_vector_rotation.sv =====
// testbench for the euler xyz vector rotation block: random and corner beats against a predictor
`timescale 1ns / 1ps

module tb_euler_xyz_vector_rotation import erot_pkg::*;;

    localparam int FRAC = 16;
    localparam longint ANG_ONE = 65536;
    localparam longint ANG_FULL = 360 * ANG_ONE;
    localparam longint ANG_QTR = 90 * ANG_ONE;
    localparam longint ANG_HALFQ = 45 * ANG_ONE;
    localparam longint unsigned RAD_Q32 = 64'd74961321;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned FMASK = (64'd1 << FRAC) - 1;
    localparam int STALL_LIMIT = 5000;
    localparam int N_RANDOM = 1600;

    // rotation predictor and queue of expected rotated vectors
    class rotation_scoreboard;
        t_out_beat expected_q[$];
        int fails;

        function longint round_q30(longint unsigned v);
            return longint'((v + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
        endfunction

        // sine and cosine of a q16.16 degree angle
        function void sin_cos(input logic signed [31:0] a, output longint sn, output longint cs);
            longint r, q, d, s0, c0;
            longint unsigned md, x, x2, t;
            longint unsigned sdiv[5];
            longint unsigned cdiv[6];
            sdiv = '{110, 72, 42, 20, 6};
            cdiv = '{132, 90, 56, 30, 12, 2};
            r = longint'(a) % ANG_FULL;
            if (r < 0) begin
                r += ANG_FULL;
            end
            q = (r + ANG_HALFQ) / ANG_QTR;
            d = r - q * ANG_QTR;
            md = (d < 0) ? longint'(-d) : longint'(d);
            x = (md * RAD_Q32 + (64'd1 << 17)) >> 18;
            x2 = (x * x) >> 30;
            t = ONE_Q30;
            for (int k = 0; k < 5; k++) begin
                t = ONE_Q30 - ((x2 * t) >> 30) / sdiv[k];
            end
            s0 = round_q30((x * t) >> 30);
            if (d < 0) begin
                s0 = -s0;
            end
            t = ONE_Q30;
            for (int k = 0; k < 6; k++) begin
                t = ONE_Q30 - ((x2 * t) >> 30) / cdiv[k];
            end
            c0 = round_q30(t);
            case (t_quad'(q[1:0]))
                QUAD_0: begin sn = s0; cs = c0; end
                QUAD_1: begin sn = c0; cs = -s0; end
                QUAD_2: begin sn = -s0; cs = -c0; end
                default: begin sn = -c0; cs = s0; end
            endcase
        endfunction

        // exact product split into whole part and nonnegative fraction
        function void product(input longint a, input longint tr, output longint whole,
                              output longint unsigned frac);
            longint unsigned ma, mt, lo, hi;
            ma = (a < 0) ? longint'(-a) : longint'(a);
            mt = (tr < 0) ? longint'(-tr) : longint'(tr);
            lo = (ma & FMASK) * mt;
            hi = (ma >> FRAC) * mt + (lo >> FRAC);
            whole = longint'(hi);
            frac = lo & FMASK;
            if ((a < 0) != (tr < 0)) begin
                if (frac == 0) begin
                    whole = -whole;
                end else begin
                    whole = -whole - 1;
                    frac = (64'd1 << FRAC) - frac;
                end
            end
        endfunction

        // sum of two products, rounded half up and clipped
        function longint dot_sat(longint a, longint ta, longint b, longint tb, inout bit sat);
            longint wa, wb, w;
            longint unsigned fa, fb, f;
            product(a, ta, wa, fa);
            product(b, tb, wb, fb);
            f = fa + fb;
            w = wa + wb + longint'(f >> FRAC);
            f &= FMASK;
            w += longint'((f + (64'd1 << (FRAC - 1))) >> FRAC);
            if (w > 64'sd2147483647) begin
                sat = 1'b1;
                return 64'sd2147483647;
            end
            if (w < -64'sd2147483648) begin
                sat = 1'b1;
                return -64'sd2147483648;
            end
            return w;
        endfunction

        function void note_input(t_in_beat b);
            longint x, y, z, s, c, nx, ny, nz;
            bit sat;
            t_out_beat r;
            sat = 1'b0;
            x = longint'(b.vec_x);
            y = longint'(b.vec_y);
            z = longint'(b.vec_z);
            sin_cos(b.angle_x_deg, s, c);
            ny = dot_sat(y, c, z, -s, sat);
            nz = dot_sat(y, s, z, c, sat);
            y = ny;
            z = nz;
            sin_cos(b.angle_y_deg, s, c);
            nx = dot_sat(x, c, z, s, sat);
            nz = dot_sat(x, -s, z, c, sat);
            x = nx;
            z = nz;
            sin_cos(b.angle_z_deg, s, c);
            nx = dot_sat(x, c, y, -s, sat);
            ny = dot_sat(x, s, y, c, sat);
            r.rot_x = nx[31:0];
            r.rot_y = ny[31:0];
            r.rot_z = z[31:0];
            r.saturated = sat;
            expected_q.push_back(r);
        endfunction

        function void check(t_out_beat got);
            t_out_beat exp_b;
            if (expected_q.size() == 0) begin
                fails++;
                if (fails <= 10) begin
                    $display("unexpected result beat %h", got);
                end
                return;
            end
            exp_b = expected_q.pop_front();
            if (got.rot_x !== exp_b.rot_x || got.rot_y !== exp_b.rot_y ||
                got.rot_z !== exp_b.rot_z || got.saturated !== exp_b.saturated) begin
                fails++;
                if (fails <= 10) begin
                    $display("mismatch: exp x=%h y=%h z=%h sat=%b got x=%h y=%h z=%h sat=%b",
                             exp_b.rot_x, exp_b.rot_y, exp_b.rot_z, exp_b.saturated,
                             got.rot_x, got.rot_y, got.rot_z, got.saturated);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_beat i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_beat o_out_data;

    rotation_scoreboard sb = new();
    bit no_idle = 1'b0;
    int rx_stall = 0;
    int idle_cycles = 0;

    euler_xyz_vector_rotation u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // accepted beats on both sides
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            sb.note_input(i_in_data);
        end
        if (o_out_valid && i_out_ready) begin
            sb.check(o_out_data);
        end
    end

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || no_idle) begin
            i_out_ready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            rx_stall <= $urandom_range(1, 14) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("euler_xyz_vector_rotation regression: fail");
                $finish;
            end
        end
    end

    task automatic send_beat(t_in_beat b);
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    task automatic hold_off(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_angle();
        int sel;
        sel = $urandom_range(0, 2);
        if (sel == 0) begin
            return $urandom();
        end else if (sel == 1) begin
            // near multiples of 45 degrees, where quadrant and sign flip
            return (int'($urandom_range(0, 32)) - 16) * 45 * 65536 + int'($urandom_range(0, 8)) - 4;
        end
        return int'($urandom_range(0, 1440 * 65536)) - 720 * 65536;
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom();
        end
        return int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endfunction

    function automatic t_in_beat make_beat(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                           logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
        t_in_beat b;
        b.angle_x_deg = ax;
        b.angle_y_deg = ay;
        b.angle_z_deg = az;
        b.vec_x = vx;
        b.vec_y = vy;
        b.vec_z = vz;
        return b;
    endfunction

    initial begin
        t_in_beat dir_q[$];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner beats: zero, angle extremes, quadrant edges, clipping vectors
        dir_q.push_back(make_beat(0, 0, 0, 0, 0, 0));
        dir_q.push_back(make_beat(0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
        dir_q.push_back(make_beat(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                                  32'h0001_0000, 32'hffff_0000, 32'h0000_8000));
        dir_q.push_back(make_beat(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001,
                                  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        dir_q.push_back(make_beat(45 << 16, -(45 << 16), (45 << 16) - 1,
                                  32'h0010_0000, 32'h0020_0000, 32'h0030_0000));
        dir_q.push_back(make_beat(90 << 16, 180 << 16, 270 << 16,
                                  32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        dir_q.push_back(make_beat(360 << 16, -(360 << 16), -(90 << 16),
                                  32'h0005_0000, 32'hfffb_0000, 32'h0001_8000));
        dir_q.push_back(make_beat(135 << 16, 225 << 16, 315 << 16,
                                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        dir_q.push_back(make_beat(45 << 16, 45 << 16, 45 << 16,
                                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        dir_q.push_back(make_beat(45 << 16, 45 << 16, 45 << 16,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        dir_q.push_back(make_beat(0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
        dir_q.push_back(make_beat(180 << 16, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        dir_q.push_back(make_beat(1, -1, 32'h0000_8000, 32'h0000_0001, 32'hffff_ffff, 32'h1));
        dir_q.push_back(make_beat(-(45 << 16) - 1, (315 << 16) - 1, 32'hffff_8000,
                                  32'h0100_0000, 32'hff00_0000, 32'h0080_0000));
        dir_q.push_back(make_beat(30 << 16, 60 << 16, 120 << 16,
                                  32'h0003_0000, 32'h0004_0000, 32'h0005_0000));
        foreach (dir_q[i]) begin
            send_beat(dir_q[i]);
        end

        // random beats with sender gaps; last stretch runs without idling
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (sb.expected_q.size() != 0);
            end
            if (n == N_RANDOM - 200) begin
                no_idle = 1'b1;
            end
            if (!no_idle && $urandom_range(0, 3) == 0) begin
                hold_off($urandom_range(1, 14));
            end
            send_beat(make_beat(rand_angle(), rand_angle(), rand_angle(),
                                rand_coord(), rand_coord(), rand_coord()));
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (sb.expected_q.size() != 0);
        repeat (40) @(posedge i_clk);
        if (sb.fails == 0 && sb.expected_q.size() == 0) begin
            $display("euler_xyz_vector_rotation regression: pass");
        end else begin
            $display("euler_xyz_vector_rotation regression: fail");
        end
        $finish;
    end

endmodule
